FILE: src/srp_pkg.sv
`timescale 1ns / 1ps

package srp_pkg;

    // Placement outcome reported with every item
    typedef enum logic [1:0] {
        KIND_DROP    = 2'd0,
        KIND_ROW     = 2'd1,
        KIND_STACK   = 2'd2,
        KIND_NEW_ROW = 2'd3
    } place_kind_t;

    // Configuration register map
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SHEET_LENGTH = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SHEET_WIDTH  = 1'd1;

endpackage

FILE: src/shelf_rectangle_placer.sv
`timescale 1ns / 1ps

// Next-fit shelf placer: each input item is one part's bounding box (length
// along x, width along y, 0.01 mm units) and yields exactly one result item
// with the placement kind (dropped, on row, stacked in column, new row) and
// the part's lower-left corner. Parts are stacked in the open column when
// they are no longer than the part below and stay inside the row height,
// otherwise laid at the row cursor, otherwise start a new row above, or are
// dropped. new_sheet=1 clears the layout before its part. Throughput is one
// item per clock while the result is not stalled: the item is held in an
// input register, the decision is a single pass of adds and compares
// against the registered layout state, and the result lands in an output
// register. Input ready only drops while both registers are full and the
// result is stalled. Program sheet_length / sheet_width (both reset to 0)
// while no items are in flight.
module shelf_rectangle_placer #(
    parameter int DIM_BITS = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // configuration write port
    input  logic                                cfg_we,
    input  logic [srp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [DIM_BITS-1:0]                 cfg_data,

    // part items in
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [DIM_BITS-1:0]                 part_length,
    input  logic [DIM_BITS-1:0]                 part_width,
    input  logic                                new_sheet,

    // placement items out
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          place_kind,
    output logic [DIM_BITS-1:0]                 pos_x,
    output logic [DIM_BITS-1:0]                 pos_y
);

    // sheet size registers
    logic [DIM_BITS-1:0] sheet_length_reg;
    logic [DIM_BITS-1:0] sheet_width_reg;

    // input stage
    logic                in_full_reg;
    logic [DIM_BITS-1:0] len_reg;
    logic [DIM_BITS-1:0] wid_reg;
    logic                new_sheet_reg;

    // layout state
    logic [DIM_BITS-1:0] cursor_x_reg,    cursor_x_next;
    logic [DIM_BITS-1:0] row_start_y_reg, row_start_y_next;
    logic [DIM_BITS-1:0] row_height_reg,  row_height_next;
    logic                column_open_reg, column_open_next;
    logic [DIM_BITS-1:0] column_x_reg,    column_x_next;
    logic [DIM_BITS-1:0] stack_y_reg,     stack_y_next;
    logic [DIM_BITS-1:0] last_len_reg,    last_len_next;

    // result stage
    logic                 out_full_reg;
    srp_pkg::place_kind_t kind_reg, kind_next;
    logic [DIM_BITS-1:0]  pos_x_reg, pos_x_next;
    logic [DIM_BITS-1:0]  pos_y_reg, pos_y_next;

    logic advance;   // item in the input stage moves to the result stage
    logic take_in;

    assign advance  = in_full_reg && (!out_full_reg || out_ready);
    assign in_ready = !in_full_reg || advance;
    assign take_in  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sheet_length_reg <= '0;
            sheet_width_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                srp_pkg::REG_SHEET_LENGTH: sheet_length_reg <= cfg_data;
                srp_pkg::REG_SHEET_WIDTH:  sheet_width_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register: valid flag reset, payload not
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else if (in_ready)
            in_full_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            len_reg       <= part_length;
            wid_reg       <= part_width;
            new_sheet_reg <= new_sheet;
        end
    end

    srp_decide #(
        .DIM_BITS (DIM_BITS)
    ) u_decide (
        .len              (len_reg),
        .wid              (wid_reg),
        .new_sheet        (new_sheet_reg),
        .sheet_length     (sheet_length_reg),
        .sheet_width      (sheet_width_reg),
        .cursor_x         (cursor_x_reg),
        .row_start_y      (row_start_y_reg),
        .row_height       (row_height_reg),
        .column_open      (column_open_reg),
        .column_x         (column_x_reg),
        .stack_y          (stack_y_reg),
        .last_len         (last_len_reg),
        .cursor_x_next    (cursor_x_next),
        .row_start_y_next (row_start_y_next),
        .row_height_next  (row_height_next),
        .column_open_next (column_open_next),
        .column_x_next    (column_x_next),
        .stack_y_next     (stack_y_next),
        .last_len_next    (last_len_next),
        .kind             (kind_next),
        .px               (pos_x_next),
        .py               (pos_y_next)
    );

    // layout state moves only when an item completes its decision
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg    <= '0;
            row_start_y_reg <= '0;
            row_height_reg  <= '0;
            column_open_reg <= 1'b0;
            column_x_reg    <= '0;
            stack_y_reg     <= '0;
            last_len_reg    <= '0;
        end
        else if (advance)
        begin
            cursor_x_reg    <= cursor_x_next;
            row_start_y_reg <= row_start_y_next;
            row_height_reg  <= row_height_next;
            column_open_reg <= column_open_next;
            column_x_reg    <= column_x_next;
            stack_y_reg     <= stack_y_next;
            last_len_reg    <= last_len_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_full_reg <= 1'b0;
        else if (advance)
            out_full_reg <= 1'b1;
        else if (out_ready)
            out_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            kind_reg  <= kind_next;
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
        end
    end

    assign out_valid  = out_full_reg;
    assign place_kind = kind_reg;
    assign pos_x      = pos_x_reg;
    assign pos_y      = pos_y_reg;

endmodule

FILE: src/srp_decide.sv
`timescale 1ns / 1ps

// Placement decision for one part against the current layout state.
// Pure combinational: a few adds and compares, then a priority select.
module srp_decide #(
    parameter int DIM_BITS = 20
) (
    input  logic [DIM_BITS-1:0] len,
    input  logic [DIM_BITS-1:0] wid,
    input  logic                new_sheet,
    input  logic [DIM_BITS-1:0] sheet_length,
    input  logic [DIM_BITS-1:0] sheet_width,

    input  logic [DIM_BITS-1:0] cursor_x,
    input  logic [DIM_BITS-1:0] row_start_y,
    input  logic [DIM_BITS-1:0] row_height,
    input  logic                column_open,
    input  logic [DIM_BITS-1:0] column_x,
    input  logic [DIM_BITS-1:0] stack_y,
    input  logic [DIM_BITS-1:0] last_len,

    output logic [DIM_BITS-1:0] cursor_x_next,
    output logic [DIM_BITS-1:0] row_start_y_next,
    output logic [DIM_BITS-1:0] row_height_next,
    output logic                column_open_next,
    output logic [DIM_BITS-1:0] column_x_next,
    output logic [DIM_BITS-1:0] stack_y_next,
    output logic [DIM_BITS-1:0] last_len_next,

    output srp_pkg::place_kind_t kind,
    output logic [DIM_BITS-1:0]  px,
    output logic [DIM_BITS-1:0]  py
);

    localparam int SW = DIM_BITS + 2;

    // state as seen by this part (cleared when a new sheet starts)
    logic [DIM_BITS-1:0] cx, rsy, rh, cxo, sy, ll;
    logic                co;

    logic [SW-1:0] cx_plus_len;
    logic [SW-1:0] sy_plus_wid;
    logic [SW-1:0] row_top;
    logic [SW-1:0] rsy_plus_wid;
    logic [SW-1:0] new_row_top;
    logic          fit_stack, fit_row, fit_new_row;

    always_comb
    begin
        cx  = new_sheet ? '0 : cursor_x;
        rsy = new_sheet ? '0 : row_start_y;
        rh  = new_sheet ? '0 : row_height;
        co  = new_sheet ? 1'b0 : column_open;
        cxo = new_sheet ? '0 : column_x;
        sy  = new_sheet ? '0 : stack_y;
        ll  = new_sheet ? '0 : last_len;
    end

    // sums kept two bits wider so nothing wraps
    assign cx_plus_len  = SW'(cx) + SW'(len);
    assign sy_plus_wid  = SW'(sy) + SW'(wid);
    assign row_top      = SW'(rsy) + SW'(rh);
    assign rsy_plus_wid = SW'(rsy) + SW'(wid);
    assign new_row_top  = rsy_plus_wid + SW'(rh);

    assign fit_stack   = co && (len <= ll) && (sy_plus_wid <= row_top);
    assign fit_row     = (cx_plus_len <= SW'(sheet_length)) &&
                         (rsy_plus_wid <= SW'(sheet_width));
    assign fit_new_row = new_row_top <= SW'(sheet_width);

    always_comb
    begin
        cursor_x_next    = cx;
        row_start_y_next = rsy;
        row_height_next  = rh;
        column_open_next = co;
        column_x_next    = cxo;
        stack_y_next     = sy;
        last_len_next    = ll;
        kind             = srp_pkg::KIND_DROP;
        px               = '0;
        py               = '0;

        priority if (fit_stack)
        begin
            kind          = srp_pkg::KIND_STACK;
            px            = cxo;
            py            = sy;
            stack_y_next  = sy_plus_wid[DIM_BITS-1:0];
            last_len_next = len;
        end
        else if (fit_row)
        begin
            kind             = srp_pkg::KIND_ROW;
            px               = cx;
            py               = rsy;
            column_open_next = 1'b1;
            column_x_next    = cx;
            stack_y_next     = rsy_plus_wid[DIM_BITS-1:0];
            last_len_next    = len;
            cursor_x_next    = cx_plus_len[DIM_BITS-1:0];
            row_height_next  = (wid > rh) ? wid : rh;
        end
        else if (fit_new_row)
        begin
            kind             = srp_pkg::KIND_NEW_ROW;
            row_start_y_next = row_top[DIM_BITS-1:0];
            px               = '0;
            py               = row_top[DIM_BITS-1:0];
            cursor_x_next    = len;
            row_height_next  = wid;
            column_open_next = 1'b0;
        end
        else
        begin
            column_open_next = 1'b0;
        end
    end

endmodule

FILE: bench/placement_checker.sv
`timescale 1ns / 1ps

module placement_checker #(
    parameter int DIM_BITS = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [srp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [DIM_BITS-1:0]                 cfg_data,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [DIM_BITS-1:0]                 part_length,
    input  logic [DIM_BITS-1:0]                 part_width,
    input  logic                                new_sheet,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [1:0]                          place_kind,
    input  logic [DIM_BITS-1:0]                 pos_x,
    input  logic [DIM_BITS-1:0]                 pos_y,
    output int                                  fail_count,
    output int                                  outstanding,
    output logic [3:0][31:0]                    kind_tally
);

    typedef logic [DIM_BITS-1:0] dim_t;
    // two spare bits: the widest test adds three dims
    typedef logic [DIM_BITS+1:0] wide_t;

    typedef struct packed {
        srp_pkg::place_kind_t kind;
        dim_t                 x;
        dim_t                 y;
    } placement_t;

    dim_t       sheet_len;
    dim_t       sheet_wid;

    dim_t       cur_x;
    dim_t       row_base;
    dim_t       row_h;
    logic       col_open;
    dim_t       col_x;
    dim_t       col_top;
    dim_t       col_top_len;

    placement_t placements_due[$];

    function automatic void empty_sheet();
        cur_x       = '0;
        row_base    = '0;
        row_h       = '0;
        col_open    = 1'b0;
        col_x       = '0;
        col_top     = '0;
        col_top_len = '0;
    endfunction

    // stack in open column, else lay at row cursor, else open a row above, else drop
    function automatic placement_t place_part(dim_t len, dim_t wid, logic fresh);
        placement_t p;
        p.kind = srp_pkg::KIND_DROP;
        p.x    = '0;
        p.y    = '0;
        if (fresh)
            empty_sheet();
        if (col_open && len <= col_top_len &&
            wide_t'(col_top) + wide_t'(wid) <= wide_t'(row_base) + wide_t'(row_h))
        begin
            p.kind      = srp_pkg::KIND_STACK;
            p.x         = col_x;
            p.y         = col_top;
            col_top     = col_top + wid;
            col_top_len = len;
        end
        else if (wide_t'(cur_x) + wide_t'(len) <= wide_t'(sheet_len) &&
                 wide_t'(row_base) + wide_t'(wid) <= wide_t'(sheet_wid))
        begin
            p.kind      = srp_pkg::KIND_ROW;
            p.x         = cur_x;
            p.y         = row_base;
            col_open    = 1'b1;
            col_x       = cur_x;
            col_top     = row_base + wid;
            col_top_len = len;
            cur_x       = cur_x + len;
            if (wid > row_h)
                row_h = wid;
        end
        else if (wide_t'(row_base) + wide_t'(wid) + wide_t'(row_h) <= wide_t'(sheet_wid))
        begin
            row_base = row_base + row_h;
            p.kind   = srp_pkg::KIND_NEW_ROW;
            p.y      = row_base;
            cur_x    = len;
            row_h    = wid;
            col_open = 1'b0;
        end
        else
        begin
            col_open = 1'b0;
        end
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        placement_t want;
        if (!rst_n)
        begin
            sheet_len = '0;
            sheet_wid = '0;
            empty_sheet();
            placements_due.delete();
            fail_count  = 0;
            kind_tally  = '0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    srp_pkg::REG_SHEET_LENGTH: sheet_len = cfg_data;
                    srp_pkg::REG_SHEET_WIDTH:  sheet_wid = cfg_data;
                    default: ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                if (placements_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("[%0t] result with no part waiting: kind %0d at (%0d,%0d)",
                                 $time, place_kind, pos_x, pos_y);
                end
                else
                begin
                    want = placements_due.pop_front();
                    kind_tally[want.kind] = kind_tally[want.kind] + 1;
                    if (place_kind !== want.kind || pos_x !== want.x || pos_y !== want.y)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("[%0t] mismatch: expected kind %0d at (%0d,%0d), %s%0d at (%0d,%0d)",
                                     $time, want.kind, want.x, want.y, "got kind ",
                                     place_kind, pos_x, pos_y);
                    end
                end
            end

            if (in_valid && in_ready)
                placements_due.insert(placements_due.size(),
                                      place_part(part_length, part_width, new_sheet));

            outstanding <= placements_due.size();
        end
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int DIM_BITS         = 20;
    localparam int CYCLE_LIMIT      = 400000;
    // long receiver hold-off, well past the two-deep pipe
    localparam int HOLD_CYCLES      = 300;
    localparam int RANDOM_PER_PHASE = 200;
    localparam int PHASES           = 4;

    typedef logic [DIM_BITS-1:0] dim_t;

    localparam dim_t DIM_MAX = '1;

    // every block input known from time zero; reset held from the start
    logic                               clk         = 1'b0;
    logic                               rst_n       = 1'b0;
    logic                               cfg_we      = 1'b0;
    logic [srp_pkg::CFG_INDEX_BITS-1:0] cfg_index   = '0;
    dim_t                               cfg_data    = '0;
    logic                               in_valid    = 1'b0;
    logic                               in_ready;
    dim_t                               part_length = '0;
    dim_t                               part_width  = '0;
    logic                               new_sheet   = 1'b0;
    logic                               out_valid;
    logic                               out_ready   = 1'b0;
    logic [1:0]                         place_kind;
    dim_t                               pos_x;
    dim_t                               pos_y;

    int                         fail_count;
    int                         outstanding;
    logic [3:0][31:0]           kind_tally;

    // traffic shaping, percent of cycles
    int                         send_idle_pct = 0;
    int                         stall_pct     = 0;

    // hold-off requests: receiver serves one stretch per bump
    int                         hold_requests = 0;
    int                         hold_served;
    int                         hold_left;

    // sheet as last programmed; steers the random part sizes
    dim_t                       sheet_len;
    dim_t                       sheet_wid;
    dim_t                       prev_len;

    int                         parts_sent    = 0;
    int                         settings_used = 0;
    int                         cycle_count   = 0;

    shelf_rectangle_placer #(
        .DIM_BITS(DIM_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .part_length(part_length),
        .part_width (part_width),
        .new_sheet  (new_sheet),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .place_kind (place_kind),
        .pos_x      (pos_x),
        .pos_y      (pos_y)
    );

    placement_checker #(
        .DIM_BITS(DIM_BITS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .part_length(part_length),
        .part_width (part_width),
        .new_sheet  (new_sheet),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .place_kind (place_kind),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .fail_count (fail_count),
        .outstanding(outstanding),
        .kind_tally (kind_tally)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
            $display("shelf_rectangle_placer test failed");
            $finish;
        end
    end

    // result side: random stalls, plus a counted hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            hold_served = 0;
            hold_left   = 0;
        end
        else
        begin
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99, 0) >= stall_pct);
            end
        end
    end

    // present one part, hold it until taken, then maybe go idle a while;
    // valid stays up across back-to-back items
    task automatic offer_part(input dim_t len, input dim_t wid, input logic fresh);
        int gap;
        in_valid    <= 1'b1;
        part_length <= len;
        part_width  <= wid;
        new_sheet   <= fresh;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        parts_sent++;
        gap = 0;
        while (gap < 40 && $urandom_range(99, 0) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering and wait for every predicted placement to come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // only called with the pipe empty
    task automatic set_sheet(input dim_t len, input dim_t wid);
        cfg_we    <= 1'b1;
        cfg_index <= srp_pkg::REG_SHEET_LENGTH;
        cfg_data  <= len;
        @(posedge clk);
        cfg_index <= srp_pkg::REG_SHEET_WIDTH;
        cfg_data  <= wid;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sheet_len = len;
        sheet_wid = wid;
        settings_used++;
    endtask

    function automatic dim_t corner_value(input dim_t span);
        case ($urandom_range(3, 0))
            0:       return '0;
            1:       return DIM_MAX;
            2:       return span;
            default: return span >> 1;
        endcase
    endfunction

    // part sizes scaled to the sheet so rows fill, columns stack and new
    // rows open; a slice of full-range and corner values keeps all bits moving
    task automatic draw_part(output dim_t len, output dim_t wid);
        int unsigned sel;
        int unsigned lspan;
        int unsigned wspan;
        sel   = $urandom_range(99, 0);
        lspan = (sheet_len / 6 > 1) ? sheet_len / 6 : 2;
        wspan = (sheet_wid / 5 > 1) ? sheet_wid / 5 : 2;
        if (sel < 45)
        begin
            len = dim_t'($urandom_range(lspan, 0));
            wid = dim_t'($urandom_range(wspan, 0));
        end
        else if (sel < 75)
        begin
            // no longer than the last part and thin: a stacking candidate
            len = dim_t'($urandom_range(prev_len, 0));
            wid = dim_t'($urandom_range(wspan / 3, 0));
        end
        else if (sel < 85)
        begin
            len = dim_t'($urandom);
            wid = dim_t'($urandom);
        end
        else if (sel < 93)
        begin
            len = corner_value(sheet_len);
            wid = corner_value(sheet_wid);
        end
        else
        begin
            // tall and narrow, raises the row so later parts can stack
            len = dim_t'($urandom_range(lspan / 4, 0));
            wid = dim_t'($urandom_range(sheet_wid / 2, 0));
        end
        prev_len = len;
    endtask

    initial
    begin
        dim_t len;
        dim_t wid;
        logic fresh;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: back-to-back, receiver always ready
        set_sheet(dim_t'(1000), dim_t'(1000));
        offer_part(dim_t'(300), dim_t'(200), 1'b1);   // first part on a fresh sheet
        offer_part(dim_t'(200), dim_t'(100), 1'b0);   // too tall to stack, next on row
        offer_part(dim_t'(150), dim_t'(80),  1'b0);   // stacks in that column
        offer_part(dim_t'(150), dim_t'(20),  1'b0);   // stack reaches row height exactly
        offer_part(dim_t'(160), dim_t'(0),   1'b0);   // longer than column top, zero width
        offer_part(dim_t'(340), dim_t'(300), 1'b0);   // ends exactly at sheet length
        offer_part(dim_t'(1),   dim_t'(1),   1'b0);   // no room: opens a new row
        offer_part(dim_t'(1),   dim_t'(1),   1'b0);   // column closed, goes on row
        offer_part(DIM_MAX,     dim_t'(5),   1'b0);   // overlong part, still a new row
        offer_part(dim_t'(0),   DIM_MAX,     1'b0);   // far too wide: dropped
        offer_part(dim_t'(0),   dim_t'(1000), 1'b1);  // full sheet width after clear
        offer_part(dim_t'(0),   dim_t'(0),   1'b0);   // zero-size part stacks
        offer_part(dim_t'(1000), dim_t'(0),  1'b0);
        offer_part(DIM_MAX,     DIM_MAX,     1'b0);
        wait_drained();

        // empty sheet: only zero-width parts find a place
        set_sheet('0, '0);
        offer_part(dim_t'(0), dim_t'(0), 1'b1);
        offer_part(dim_t'(1), dim_t'(0), 1'b0);
        offer_part(dim_t'(0), dim_t'(1), 1'b0);
        wait_drained();

        // largest sheet with largest parts
        set_sheet(DIM_MAX, DIM_MAX);
        offer_part(DIM_MAX,   DIM_MAX,   1'b1);
        offer_part(DIM_MAX,   DIM_MAX,   1'b0);
        offer_part(dim_t'(0), dim_t'(0), 1'b0);
        offer_part(dim_t'(0), dim_t'(0), 1'b0);
        offer_part(dim_t'(1), dim_t'(0), 1'b0);
        wait_drained();

        // random phases, each on its own sheet and traffic pattern
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     <= 0;
                    set_sheet(dim_t'(20000), dim_t'(15000));
                    // receiver blocks while parts keep coming: pipe fills
                    hold_requests <= hold_requests + 1;
                end
                1:
                begin
                    send_idle_pct = 85;
                    stall_pct     <= 0;
                    set_sheet(DIM_MAX, DIM_MAX);
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     <= 85;
                    set_sheet(dim_t'(3000), dim_t'(2500));
                end
                default:
                begin
                    send_idle_pct = 14;
                    stall_pct     <= 14;
                    set_sheet(dim_t'($urandom_range(50000, 200)),
                              dim_t'($urandom_range(50000, 200)));
                end
            endcase
            prev_len = sheet_len / 8;
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                draw_part(len, wid);
                fresh = (i == 0) || ($urandom_range(99, 0) < 4);
                offer_part(len, wid, fresh);
            end
            wait_drained();
        end

        // all results back; a few more cycles to catch anything stray
        repeat (8) @(posedge clk);

        $display("Summary: %0d parts over %0d sheet settings, in four traffic patterns",
                 parts_sent, settings_used);
        $display("Outcomes: dropped %0d, on row %0d, stacked %0d, new row %0d",
                 kind_tally[srp_pkg::KIND_DROP], kind_tally[srp_pkg::KIND_ROW],
                 kind_tally[srp_pkg::KIND_STACK], kind_tally[srp_pkg::KIND_NEW_ROW]);
        if (fail_count == 0 && outstanding == 0)
            $display("shelf_rectangle_placer test passed");
        else
            $display("shelf_rectangle_placer test failed");
        $finish;
    end

endmodule

FILE: sim.f
src/srp_pkg.sv
src/srp_decide.sv
src/shelf_rectangle_placer.sv
bench/placement_checker.sv
bench/tb.sv
